### rtl/prpu_pkg.sv
// Package: shared types and codes for the page replacement unit.
package prpu_pkg;

    localparam int FRAMES = 4;
    localparam int PAGES  = 16;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_LFU  = 2'd1,
        POL_MFU  = 2'd2,
        POL_LRU  = 2'd3
    } policy_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_SHIFT,
        ST_LOAD,
        ST_OUT
    } state_t;

endpackage

### rtl/page_replacement_policy_unit.sv
// Top level: page replacement unit with a frame-by-frame sequencer.
//
// Usage: one input channel (in_valid/in_ready) carries page_index and
// reference_time; one output channel (out_valid/out_ready) returns was_miss,
// evicted_valid, evicted_page and frame_slot, one result item per item.
// policy_reg is written through cfg_we/cfg_data; the user must write it only
// while the block is idle; the block itself does not enforce this. A hit walks
// the frames in LOOKUP and stops at the match; a fill passes LOOKUP and LOAD;
// an eviction passes LOOKUP, SCAN, SHIFT (to the last frame for FIFO, LFU, MFU)
// and LOAD: the victim scan and the shift walk one frame per cycle through one
// shared comparator and one frame move. The result then waits in the output
// register; in_ready is low until it is taken and rises the cycle after, so
// a stalled receiver holds the whole block. Reset clears the use counts,
// resident flags, fill count and policy; frame contents are written before
// they are read.
// Use counts persist across evictions and saturate at all ones.
module page_replacement_policy_unit
    import prpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  page_index,
    input  logic [15:0] reference_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        was_miss,
    output logic        evicted_valid,
    output logic [3:0]  evicted_page,
    output logic [1:0]  frame_slot
);

    localparam int FW = $clog2(FRAMES);
    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW = $clog2(FRAMES + 1);

    state_t state_reg, state_next;
    policy_t policy_reg;

    logic [3:0]  frame_page_reg  [FRAMES];
    logic [15:0] frame_stamp_reg [FRAMES];
    logic [15:0] use_count_reg   [PAGES];
    logic [PAGES-1:0] resident_reg;
    logic [CW-1:0] filled_reg;

    logic [PW-1:0] page_reg;
    logic [15:0]   time_reg;
    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] vic_reg, vic_next;
    logic          miss_reg, evv_reg;
    logic [3:0]    evp_reg;
    logic [FW-1:0] slot_reg;

    logic [PW-1:0] pg_in;
    logic [PW-1:0] fp_idx, fv_idx;
    logic [15:0]   cnt_i, cnt_v;
    logic          take;

    always_comb
    begin
        pg_in = PW'(32'(page_index) % PAGES);
        fp_idx = PW'(32'(frame_page_reg[idx_reg]) % PAGES);
        fv_idx = PW'(32'(frame_page_reg[vic_reg]) % PAGES);
        cnt_i = use_count_reg[fp_idx];
        cnt_v = use_count_reg[fv_idx];
        // shared comparator, sense chosen by the policy
        case (policy_reg)
            POL_LFU: take = (cnt_i <= cnt_v);
            POL_MFU: take = (cnt_i >= cnt_v);
            POL_LRU: take = (frame_stamp_reg[idx_reg] < frame_stamp_reg[vic_reg]);
            default: take = 1'b0;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign was_miss = miss_reg;
    assign evicted_valid = evv_reg;
    assign evicted_page = evp_reg;
    assign frame_slot = 2'(slot_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        vic_next = vic_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (in_valid) state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                if (resident_reg[page_reg])
                begin
                    if (frame_page_reg[idx_reg] == 4'(page_reg)
                        || 32'(idx_reg) == FRAMES - 1)
                        state_next = ST_OUT;
                    else
                        idx_next = idx_reg + 1'b1;
                end
                else if (32'(filled_reg) < FRAMES)
                    state_next = ST_LOAD;
                else
                begin
                    vic_next = '0;
                    idx_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (take) vic_next = idx_reg;
                if (32'(idx_reg) == FRAMES - 1)
                begin
                    state_next = ST_SHIFT;
                    idx_next = take ? idx_reg : vic_reg;
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_SHIFT:
            begin
                if (policy_reg == POL_LRU || 32'(idx_reg) == FRAMES - 1)
                    state_next = ST_LOAD;
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_LOAD: state_next = ST_OUT;
            ST_OUT: if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            policy_reg <= POL_FIFO;
            resident_reg <= '0;
            filled_reg <= '0;
            idx_reg <= '0;
            vic_reg <= '0;
            for (int p = 0; p < PAGES; p++) use_count_reg[p] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            vic_reg <= vic_next;
            if (cfg_we) policy_reg <= policy_t'(cfg_data);
            case (state_reg)
                ST_LOOKUP:
                begin
                    if (resident_reg[page_reg]
                        && (frame_page_reg[idx_reg] == 4'(page_reg)
                            || 32'(idx_reg) == FRAMES - 1))
                    begin
                        if (use_count_reg[page_reg] != 16'hFFFF)
                            use_count_reg[page_reg] <= use_count_reg[page_reg] + 16'd1;
                    end
                    if (!resident_reg[page_reg] && 32'(filled_reg) < FRAMES)
                        filled_reg <= filled_reg + 1'b1;
                end
                ST_SHIFT:
                    if (idx_reg == (policy_reg == POL_LRU ? idx_reg : vic_reg)
                        && !evv_reg)
                        resident_reg[fp_idx] <= 1'b0;
                ST_LOAD: resident_reg[page_reg] <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                page_reg <= pg_in;
                time_reg <= reference_time;
                miss_reg <= 1'b0;
                evv_reg <= 1'b0;
                evp_reg <= '0;
                slot_reg <= '0;
            end
            ST_LOOKUP:
            begin
                if (resident_reg[page_reg])
                begin
                    if (frame_page_reg[idx_reg] == 4'(page_reg))
                    begin
                        slot_reg <= idx_reg;
                        if (policy_reg == POL_LRU)
                            frame_stamp_reg[idx_reg] <= time_reg;
                    end
                    else if (32'(idx_reg) == FRAMES - 1)
                    begin
                        slot_reg <= '0;
                        if (policy_reg == POL_LRU)
                            frame_stamp_reg[0] <= time_reg;
                    end
                end
                else
                begin
                    miss_reg <= 1'b1;
                    slot_reg <= FW'(filled_reg);
                end
            end
            ST_SHIFT:
            begin
                if (!evv_reg)
                begin
                    evv_reg <= 1'b1;
                    evp_reg <= frame_page_reg[idx_reg];
                end
                if (policy_reg == POL_LRU)
                    slot_reg <= idx_reg;
                else
                begin
                    slot_reg <= FW'(FRAMES - 1);
                    if (32'(idx_reg) != FRAMES - 1)
                    begin
                        frame_page_reg[idx_reg] <= frame_page_reg[idx_reg + 1'b1];
                        frame_stamp_reg[idx_reg] <= frame_stamp_reg[idx_reg + 1'b1];
                    end
                end
            end
            ST_LOAD:
            begin
                frame_page_reg[slot_reg] <= 4'(page_reg);
                frame_stamp_reg[slot_reg] <= time_reg;
            end
            default: ;
        endcase
    end

endmodule

### tb/tb_page_replacement_policy_unit.sv
// Testbench for the page replacement unit: directed and random references per policy.
`timescale 1ns / 1ps

module tb_page_replacement_policy_unit
    import prpu_pkg::*;
();

    typedef struct packed {
        logic       miss;
        logic       ev_valid;
        logic [3:0] ev_page;
        logic [1:0] slot;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  page_index;
    logic [15:0] reference_time;
    logic        out_valid;
    logic        out_ready;
    logic        was_miss;
    logic        evicted_valid;
    logic [3:0]  evicted_page;
    logic [1:0]  frame_slot;

    // shadow of the frame table
    logic [3:0]  shadow_page [FRAMES];
    logic [15:0] shadow_stamp [FRAMES];
    logic [15:0] use_count [PAGES];
    logic        resident [PAGES];
    int          filled;
    policy_t     policy;

    outcome_t    pending_outcomes [$];
    int          fail_count;
    int          refs_sent;
    int          outcomes_seen;
    int          evictions_seen;
    bit          quiet;
    logic [15:0] clock_stamp;

    page_replacement_policy_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .page_index(page_index),
        .reference_time(reference_time), .out_valid(out_valid),
        .out_ready(out_ready), .was_miss(was_miss), .evicted_valid(evicted_valid),
        .evicted_page(evicted_page), .frame_slot(frame_slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int choose_victim();
        int v;
        v = 0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (policy == POL_LFU && use_count[shadow_page[i]] <= use_count[shadow_page[v]])
                v = i;
            else if (policy == POL_MFU && use_count[shadow_page[i]] >= use_count[shadow_page[v]])
                v = i;
            else if (policy == POL_LRU && shadow_stamp[i] < shadow_stamp[v])
                v = i;
        end
        return v;
    endfunction

    function automatic outcome_t reference_outcome(logic [3:0] pg, logic [15:0] t);
        outcome_t r;
        int v;
        r = '0;
        if (resident[pg])
        begin
            for (int i = filled - 1; i >= 0; i--)
                if (shadow_page[i] == pg)
                    r.slot = 2'(i);
            if (use_count[pg] != 16'hFFFF)
                use_count[pg]++;
            if (policy == POL_LRU)
                shadow_stamp[r.slot] = t;
        end
        else
        begin
            r.miss = 1'b1;
            if (filled < FRAMES)
            begin
                r.slot = 2'(filled);
                filled++;
            end
            else
            begin
                v = choose_victim();
                r.ev_valid = 1'b1;
                r.ev_page = shadow_page[v];
                resident[shadow_page[v]] = 1'b0;
                if (policy == POL_LRU)
                    r.slot = 2'(v);
                else
                begin
                    for (int i = v; i + 1 < FRAMES; i++)
                    begin
                        shadow_page[i] = shadow_page[i + 1];
                        shadow_stamp[i] = shadow_stamp[i + 1];
                    end
                    r.slot = 2'(FRAMES - 1);
                end
            end
            shadow_page[r.slot] = pg;
            shadow_stamp[r.slot] = t;
            resident[pg] = 1'b1;
        end
        return r;
    endfunction

    // valid stays high between items sent back to back; it drops for idling
    // and in drain
    task automatic send_reference(logic [3:0] pg, logic [15:0] t);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        page_index     <= pg;
        reference_time <= t;
        in_valid       <= 1'b1;
        pending_outcomes.push_back(reference_outcome(pg, t));
        refs_sent++;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_policy(policy_t p);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= p;
        @(negedge clk);
        cfg_we   <= 1'b0;
        policy = p;
    endtask

    // receiver: random stalls, checks each result item in order
    initial
    begin
        outcome_t e;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                outcomes_seen++;
                if (pending_outcomes.size() == 0)
                begin
                    $error("result item with none expected");
                    fail_count++;
                end
                else
                begin
                    e = pending_outcomes.pop_front();
                    evictions_seen += e.ev_valid;
                    if (was_miss !== e.miss)
                    begin
                        $error("was_miss exp %0d got %0d", e.miss, was_miss);
                        fail_count++;
                    end
                    if (evicted_valid !== e.ev_valid)
                    begin
                        $error("evicted_valid exp %0d got %0d", e.ev_valid, evicted_valid);
                        fail_count++;
                    end
                    if (evicted_page !== e.ev_page)
                    begin
                        $error("evicted_page exp %0d got %0d", e.ev_page, evicted_page);
                        fail_count++;
                    end
                    if (frame_slot !== e.slot)
                    begin
                        $error("frame_slot exp %0d got %0d", e.slot, frame_slot);
                        fail_count++;
                    end
                end
            end
        end
    end

    task automatic test_directed_fill_and_hits();
        send_reference(4'd0, 16'h0000);
        send_reference(4'd15, 16'hFFFF);
        send_reference(4'd0, 16'h0001);
        send_reference(4'd5, 16'h8000);
        send_reference(4'd10, 16'h7FFF);
        send_reference(4'd15, 16'h0002);
        send_reference(4'd3, 16'h0003);   // FIFO eviction
        send_reference(4'd5, 16'h0004);
    endtask

    task automatic test_directed_policies();
        set_policy(POL_LFU);
        send_reference(4'd5, 16'h0010);
        send_reference(4'd1, 16'h0011);
        send_reference(4'd2, 16'h0012);
        set_policy(POL_MFU);
        send_reference(4'd7, 16'h0020);
        send_reference(4'd8, 16'h0021);
        set_policy(POL_LRU);
        send_reference(4'd9, 16'h0030);
        send_reference(4'd7, 16'hFFFF);
        send_reference(4'd12, 16'h0000);
        send_reference(4'd13, 16'h0031);
        send_reference(4'd14, 16'h0032);
        // pause the sender until every result has come back
        drain();
        send_reference(4'd12, 16'h0040);
    endtask

    // mostly a small working set so hits and counts build up
    task automatic test_random_mix(int n);
        logic [3:0] pg;
        for (int k = 0; k < n; k++)
        begin
            if (k % 150 == 0)
                set_policy(policy_t'($urandom_range(0, 3)));
            pg = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 5)) : 4'($urandom);
            if ($urandom_range(0, 9) == 0)
                send_reference(pg, 16'($urandom));
            else
            begin
                clock_stamp += 16'($urandom_range(1, 3));
                send_reference(pg, clock_stamp);
            end
        end
    endtask

    task automatic test_quiet_run(int n);
        quiet = 1'b1;
        set_policy(POL_LRU);
        test_random_mix(n);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        page_index = '0;
        reference_time = '0;
        quiet = 1'b0;
        fail_count = 0;
        refs_sent = 0;
        outcomes_seen = 0;
        evictions_seen = 0;
        clock_stamp = '0;
        filled = 0;
        policy = POL_FIFO;
        for (int i = 0; i < PAGES; i++)
        begin
            use_count[i] = '0;
            resident[i] = 1'b0;
        end
        for (int i = 0; i < FRAMES; i++)
        begin
            shadow_page[i] = '0;
            shadow_stamp[i] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_fill_and_hits();
        test_directed_policies();
        test_random_mix(1150);
        test_quiet_run(200);
        drain();

        $display("Sent %0d references, checked %0d results, %0d evictions",
                 refs_sent, outcomes_seen, evictions_seen);
        $display("Covered FIFO, LFU, MFU and LRU with random stalls on both sides");
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### page_replacement_policy_unit.f
rtl/prpu_pkg.sv
rtl/page_replacement_policy_unit.sv
tb/tb_page_replacement_policy_unit.sv
